// File: src/assert_macros.svh
// Assertion helpers for the RTL. Every check is clocked on clk_i and
// is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define STS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The expression must never be true out of reset.
`define STS_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// File: src/sts_pkg.sv
// ----------------------------------------------------------------------------
// Screenshot transfer session package
// Constants, codes and the request and result types shared by the session unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  localparam int FRAME_BYTES         = 153600;
  localparam int MAX_CHUNK           = 500;
  localparam int MAX_RETRIES         = 3;
  localparam int PACKET_BUFFER_BYTES = 1024;
  localparam int BEGIN_PACKET_BYTES  = 17;
  localparam int END_PACKET_BYTES    = 21;
  localparam int DATA_HEADER         = 17;

  localparam logic [31:0] CAPTURE_TIMEOUT_RST = 32'd30000;
  localparam logic [31:0] ACK_TIMEOUT_RST     = 32'd3000;
  localparam logic [31:0] WINDOW_RST          = 32'd300000;

  // Depth of the queue between the classifier and the session engine.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    CMD_MSG      = 3'd0,
    CMD_CAPTURED = 3'd1,
    CMD_REQUEST  = 3'd2,
    CMD_SENT     = 3'd3,
    CMD_POLL     = 3'd4
  } cmd_e;

  typedef enum logic [7:0] {
    OP_START  = 8'd1,
    OP_ACK    = 8'd2,
    OP_FINISH = 8'd3,
    OP_CANCEL = 8'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEN   = 3'd1,
    ST_TIMEOUT   = 3'd2,
    ST_BAD_STATE = 3'd3,
    ST_BUSY      = 3'd4,
    ST_BAD_ID    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PK_NONE  = 2'd0,
    PK_BEGIN = 2'd1,
    PK_DATA  = 2'd2,
    PK_END   = 2'd3
  } pkind_e;

  typedef enum logic [1:0] {
    CFG_CAPTURE = 2'd0,
    CFG_ACK     = 2'd1,
    CFG_WINDOW  = 2'd2
  } cfg_idx_e;

  // A classified request as it travels through the queue.
  typedef struct packed {
    logic [2:0]  cmd;
    logic        len_ok;
    logic [7:0]  opcode;
    logic [15:0] msg_session;
    logic [15:0] msg_sequence;
    logic [15:0] requester_id;
    logic [63:0] now;
    logic [63:0] cap_deadline;
    logic [63:0] ack_deadline;
    logic        frame_ok;
    logic [15:0] capacity;
    logic        begin_fits;
    logic        end_fits;
    logic [8:0]  chunk;
  } item_t;

  typedef struct packed {
    logic        reply;
    logic [2:0]  status;
    logic        capture;
    logic        release_res;
    logic        accepted;
    logic [1:0]  packet_kind;
    logic [15:0] packet_sequence;
    logic [17:0] packet_offset;
    logic [8:0]  packet_payload_bytes;
    logic [10:0] packet_len;
    logic [8:0]  packet_total;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// File: src/sts_intf.sv
// ----------------------------------------------------------------------------
// Screenshot transfer session channels
// Request, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [7:0]  msg_opcode;
  logic [7:0]  msg_length;
  logic [15:0] msg_session;
  logic [15:0] msg_sequence;
  logic [15:0] requester_id;
  logic [63:0] now_ms;
  logic        frame_present;
  logic [19:0] frame_bytes;
  logic [15:0] capacity;

  modport source (output valid, command, msg_opcode, msg_length, msg_session,
                  msg_sequence, requester_id, now_ms, frame_present, frame_bytes,
                  capacity, input ready);
  modport sink (input valid, command, msg_opcode, msg_length, msg_session,
                msg_sequence, requester_id, now_ms, frame_present, frame_bytes,
                capacity, output ready);
endinterface

interface sts_out_if;
  logic        valid;
  logic        ready;
  logic        reply;
  logic [2:0]  status;
  logic        capture;
  logic        release_res;
  logic        accepted;
  logic [1:0]  packet_kind;
  logic [15:0] packet_sequence;
  logic [17:0] packet_offset;
  logic [8:0]  packet_payload_bytes;
  logic [10:0] packet_len;
  logic [8:0]  packet_total;

  modport source (output valid, reply, status, capture, release_res, accepted,
                  packet_kind, packet_sequence, packet_offset, packet_payload_bytes,
                  packet_len, packet_total, input ready);
  modport sink (input valid, reply, status, capture, release_res, accepted,
                packet_kind, packet_sequence, packet_offset, packet_payload_bytes,
                packet_len, packet_total, output ready);
endinterface

interface sts_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/sts_front.sv
// ----------------------------------------------------------------------------
// Session request classifier
// Holds the timing registers and turns each request into a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  sts_in_if.sink             in_i,
  sts_cfg_if.sink            cfg_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output sts_pkg::item_t     item_o,
  output logic [31:0]        window_o
);

  logic [31:0] cap_to_q, cap_to_d;
  logic [31:0] ack_to_q, ack_to_d;
  logic [31:0] win_q, win_d;
  logic        len_ok;
  logic [15:0] room;
  logic [15:0] avail;
  logic [15:0] even;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cap_to_d = cap_to_q;
    ack_to_d = ack_to_q;
    win_d    = win_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        sts_pkg::CFG_CAPTURE: cap_to_d = cfg_i.data;
        sts_pkg::CFG_ACK:     ack_to_d = cfg_i.data;
        sts_pkg::CFG_WINDOW:  win_d    = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_to_q <= sts_pkg::CAPTURE_TIMEOUT_RST;
      ack_to_q <= sts_pkg::ACK_TIMEOUT_RST;
      win_q    <= sts_pkg::WINDOW_RST;
    end else begin
      cap_to_q <= cap_to_d;
      ack_to_q <= ack_to_d;
      win_q    <= win_d;
    end
  end

  assign window_o   = win_q;
  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  always_comb begin
    case (in_i.msg_opcode)
      sts_pkg::OP_START:  len_ok = (in_i.msg_length == 8'd1);
      sts_pkg::OP_ACK:    len_ok = (in_i.msg_length == 8'd5);
      sts_pkg::OP_FINISH,
      sts_pkg::OP_CANCEL: len_ok = (in_i.msg_length == 8'd3);
      default:            len_ok = 1'b0;
    endcase
  end

  // Room for begin and end packets, and the even data chunk the capacity allows.
  assign room  = (in_i.capacity < 16'(sts_pkg::PACKET_BUFFER_BYTES)) ? in_i.capacity
                                                    : 16'(sts_pkg::PACKET_BUFFER_BYTES);
  assign avail = in_i.capacity - 16'(sts_pkg::DATA_HEADER);
  assign even  = {avail[15:1], 1'b0};

  always_comb begin
    item_o.cmd          = in_i.command;
    item_o.len_ok       = len_ok;
    item_o.opcode       = in_i.msg_opcode;
    item_o.msg_session  = in_i.msg_session;
    item_o.msg_sequence = in_i.msg_sequence;
    item_o.requester_id = in_i.requester_id;
    item_o.now          = in_i.now_ms;
    item_o.cap_deadline = in_i.now_ms + {32'd0, cap_to_q};
    item_o.ack_deadline = in_i.now_ms + {32'd0, ack_to_q};
    item_o.frame_ok     = in_i.frame_present
                          && (in_i.frame_bytes == 20'(sts_pkg::FRAME_BYTES));
    item_o.capacity     = in_i.capacity;
    item_o.begin_fits   = 16'(sts_pkg::BEGIN_PACKET_BYTES) <= room;
    item_o.end_fits     = 16'(sts_pkg::END_PACKET_BYTES) <= room;
    if (in_i.capacity <= 16'(sts_pkg::DATA_HEADER)) begin
      item_o.chunk = 9'd0;
    end else if (even > 16'(sts_pkg::MAX_CHUNK)) begin
      item_o.chunk = 9'(sts_pkg::MAX_CHUNK);
    end else begin
      item_o.chunk = even[8:0];
    end
  end

endmodule

`default_nettype wire

// File: src/sts_queue.sv
// ----------------------------------------------------------------------------
// Session request queue
// Short first-in first-out buffer between the classifier and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire sts_pkg::item_t  item_i,
  input  wire logic            pop_i,
  output sts_pkg::item_t       item_o,
  output sts_pkg::q_stat_t     stat_o
);

  localparam int PtrW = (sts_pkg::QUEUE_DEPTH > 1) ? $clog2(sts_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(sts_pkg::QUEUE_DEPTH + 1);

  sts_pkg::item_t mem_q [sts_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    if (p == PtrW'(sts_pkg::QUEUE_DEPTH - 1)) begin
      bump = '0;
    end else begin
      bump = p + PtrW'(1);
    end
  endfunction

  always_comb begin
    wr_d  = push_i ? bump(wr_q) : wr_q;
    rd_d  = pop_i ? bump(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CntW'(sts_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// File: src/sts_back.sv
// ----------------------------------------------------------------------------
// Session engine
// Keeps the session state and builds one registered result per request.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sts_pkg::item_t    item_i,
  input  wire sts_pkg::q_stat_t  stat_i,
  input  wire logic [31:0]       window_i,
  output logic                   pop_o,
  sts_out_if.source              out_o
);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_CAPTURING = 3'd1,
    PH_BEGIN     = 3'd2,
    PH_DATA      = 3'd3,
    PH_END       = 3'd4,
    PH_COMPLETE  = 3'd5,
    PH_FAILED    = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] sess_q, sess_d;
  logic [15:0] seq_q, seq_d;
  logic [63:0] dl_q, dl_d;
  logic        wait_q, wait_d;
  logic [1:0]  retry_q, retry_d;
  logic [10:0] plen_q, plen_d;
  logic [1:0]  pkind_q, pkind_d;
  logic [17:0] off_q, off_d;
  logic [8:0]  pay_q, pay_d;
  logic [8:0]  npkt_q, npkt_d;
  logic [63:0] done_q, done_d;
  logic        ovalid_q, ovalid_d;
  sts_pkg::res_t res_q, res_d;

  logic        active;
  logic        past_dl;
  logic        recent;
  logic        emit;
  logic [19:0] remain;
  logic [8:0]  cnt;
  logic [10:0] dlen;
  logic [63:0] since;

  assign pop_o   = !stat_i.empty && (!ovalid_q || out_o.ready);
  assign active  = (phase_q == PH_CAPTURING) || (phase_q == PH_BEGIN)
                   || (phase_q == PH_DATA) || (phase_q == PH_END);
  assign past_dl = item_i.now >= dl_q;
  assign since   = item_i.now - done_q;
  assign recent  = (phase_q == PH_COMPLETE) && (since < {32'd0, window_i});
  assign remain  = ({2'b00, off_q} < 20'(sts_pkg::FRAME_BYTES))
                   ? 20'(sts_pkg::FRAME_BYTES) - {2'b00, off_q} : 20'd0;
  assign cnt     = ({11'd0, item_i.chunk} > remain) ? remain[8:0] : item_i.chunk;
  assign dlen    = 11'(sts_pkg::DATA_HEADER) + {2'b00, cnt};

  always_comb begin
    phase_d  = phase_q;
    sess_d   = sess_q;
    seq_d    = seq_q;
    dl_d     = dl_q;
    wait_d   = wait_q;
    retry_d  = retry_q;
    plen_d   = plen_q;
    pkind_d  = pkind_q;
    off_d    = off_q;
    pay_d    = pay_q;
    npkt_d   = npkt_q;
    done_d   = done_q;
    res_d    = '0;
    emit     = 1'b0;
    ovalid_d = ovalid_q && !out_o.ready;

    if (pop_o) begin
      ovalid_d = 1'b1;
      case (item_i.cmd)
        sts_pkg::CMD_MSG: begin
          if (!item_i.len_ok) begin
            res_d.reply  = 1'b1;
            res_d.status = sts_pkg::ST_BAD_LEN;
          end else if (item_i.opcode == sts_pkg::OP_START) begin
            if (active) begin
              res_d.reply  = 1'b1;
              res_d.status = sts_pkg::ST_BUSY;
            end else if (item_i.requester_id == 16'd0) begin
              res_d.reply  = 1'b1;
              res_d.status = sts_pkg::ST_BAD_ID;
            end else begin
              phase_d = PH_CAPTURING;
              sess_d  = item_i.requester_id;
              seq_d   = '0;
              dl_d    = item_i.cap_deadline;
              wait_d  = 1'b0;
              retry_d = '0;
              plen_d  = '0;
              pkind_d = '0;
              off_d   = '0;
              pay_d   = '0;
              npkt_d  = '0;
              done_d  = '0;
              res_d.capture     = 1'b1;
              res_d.release_res = 1'b1;
            end
          end else if (item_i.msg_session == 16'd0 || item_i.msg_session != sess_q) begin
            res_d.reply  = 1'b1;
            res_d.status = sts_pkg::ST_BAD_STATE;
          end else if (item_i.opcode == sts_pkg::OP_ACK) begin
            if (!wait_q || item_i.msg_sequence != seq_q) begin
              res_d.reply  = 1'b1;
              res_d.status = sts_pkg::ST_BAD_STATE;
            end else begin
              wait_d  = 1'b0;
              retry_d = '0;
              plen_d  = '0;
              seq_d   = seq_q + 16'd1;
              case (phase_q)
                PH_BEGIN: phase_d = PH_DATA;
                PH_DATA: begin
                  off_d  = off_q + {9'd0, pay_q};
                  npkt_d = npkt_q + 9'd1;
                  if (off_d == 18'(sts_pkg::FRAME_BYTES)) begin
                    phase_d = PH_END;
                  end
                end
                PH_END: begin
                  phase_d = PH_COMPLETE;
                  done_d  = item_i.now;
                  res_d.reply       = 1'b1;
                  res_d.status      = sts_pkg::ST_OK;
                  res_d.release_res = 1'b1;
                end
                default: begin
                  res_d.reply  = 1'b1;
                  res_d.status = sts_pkg::ST_BAD_STATE;
                end
              endcase
            end
          end else if (!recent && !(item_i.opcode == sts_pkg::OP_CANCEL && active)) begin
            res_d.reply  = 1'b1;
            res_d.status = sts_pkg::ST_BAD_STATE;
          end else begin
            phase_d = PH_IDLE;
            sess_d  = '0;
            seq_d   = '0;
            dl_d    = '0;
            wait_d  = 1'b0;
            retry_d = '0;
            plen_d  = '0;
            pkind_d = '0;
            off_d   = '0;
            pay_d   = '0;
            npkt_d  = '0;
            done_d  = '0;
            res_d.reply       = 1'b1;
            res_d.status      = sts_pkg::ST_OK;
            res_d.release_res = 1'b1;
          end
        end
        sts_pkg::CMD_CAPTURED: begin
          if (phase_q == PH_CAPTURING && item_i.frame_ok) begin
            phase_d        = PH_BEGIN;
            res_d.accepted = 1'b1;
          end
        end
        sts_pkg::CMD_REQUEST: begin
          if ((phase_q == PH_BEGIN || phase_q == PH_DATA || phase_q == PH_END)
              && !(wait_q && !past_dl)
              && !(wait_q && retry_q >= 2'(sts_pkg::MAX_RETRIES))) begin
            if (plen_q == '0) begin
              case (phase_q)
                PH_BEGIN: begin
                  if (item_i.begin_fits) begin
                    plen_d  = 11'(sts_pkg::BEGIN_PACKET_BYTES);
                    pkind_d = sts_pkg::PK_BEGIN;
                    emit    = 1'b1;
                  end
                end
                PH_END: begin
                  if (item_i.end_fits) begin
                    plen_d  = 11'(sts_pkg::END_PACKET_BYTES);
                    pkind_d = sts_pkg::PK_END;
                    emit    = 1'b1;
                  end
                end
                default: begin
                  if (cnt != 9'd0) begin
                    pay_d = cnt;
                    if (dlen <= 11'(sts_pkg::PACKET_BUFFER_BYTES)) begin
                      plen_d  = dlen;
                      pkind_d = sts_pkg::PK_DATA;
                      emit    = 1'b1;
                    end
                  end
                end
              endcase
            end else if ({5'd0, plen_q} <= item_i.capacity) begin
              emit = 1'b1;
            end
          end
          if (emit) begin
            res_d.packet_kind     = pkind_d;
            res_d.packet_sequence = seq_q;
            res_d.packet_len      = plen_d;
            if (pkind_d == sts_pkg::PK_DATA) begin
              res_d.packet_offset        = off_q;
              res_d.packet_payload_bytes = pay_d;
            end
            if (pkind_d == sts_pkg::PK_END) begin
              res_d.packet_total = npkt_q;
            end
          end
        end
        sts_pkg::CMD_SENT: begin
          if (plen_q != '0) begin
            if (wait_q && retry_q != 2'd3) begin
              retry_d = retry_q + 2'd1;
            end
            wait_d = 1'b1;
            dl_d   = item_i.ack_deadline;
          end
        end
        sts_pkg::CMD_POLL: begin
          if ((wait_q && past_dl && retry_q >= 2'(sts_pkg::MAX_RETRIES))
              || (phase_q == PH_CAPTURING && past_dl)) begin
            phase_d           = PH_FAILED;
            wait_d            = 1'b0;
            res_d.reply       = 1'b1;
            res_d.status      = sts_pkg::ST_TIMEOUT;
            res_d.release_res = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      sess_q   <= '0;
      seq_q    <= '0;
      dl_q     <= '0;
      wait_q   <= 1'b0;
      retry_q  <= '0;
      plen_q   <= '0;
      pkind_q  <= '0;
      off_q    <= '0;
      pay_q    <= '0;
      npkt_q   <= '0;
      done_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      sess_q   <= sess_d;
      seq_q    <= seq_d;
      dl_q     <= dl_d;
      wait_q   <= wait_d;
      retry_q  <= retry_d;
      plen_q   <= plen_d;
      pkind_q  <= pkind_d;
      off_q    <= off_d;
      pay_q    <= pay_d;
      npkt_q   <= npkt_d;
      done_q   <= done_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid                = ovalid_q;
  assign out_o.reply                = res_q.reply;
  assign out_o.status               = res_q.status;
  assign out_o.capture              = res_q.capture;
  assign out_o.release_res          = res_q.release_res;
  assign out_o.accepted             = res_q.accepted;
  assign out_o.packet_kind          = res_q.packet_kind;
  assign out_o.packet_sequence      = res_q.packet_sequence;
  assign out_o.packet_offset        = res_q.packet_offset;
  assign out_o.packet_payload_bytes = res_q.packet_payload_bytes;
  assign out_o.packet_len           = res_q.packet_len;
  assign out_o.packet_total         = res_q.packet_total;

endmodule

`default_nettype wire

// File: src/screenshot_transfer_session_unit.sv
// ----------------------------------------------------------------------------
// Screenshot transfer session unit
// Stop-and-wait upload controller for one captured frame.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while the queue has room and
// returns exactly one result per request, in order. A request is
// classified as it is accepted, waits in a two-entry queue, and is carried
// out by the session engine once it is at the queue head and the result
// register is free or being emptied. Sustained rate is one request per
// cycle while the consumer keeps output ready high; the bound is the state
// update of the session engine. The result register and the queue keep
// input acceptance going while a result waits for the consumer, and input
// ready drops only once the queue is full. Register writes take effect at
// once and must be made while no request is in flight.
`default_nettype none

`include "assert_macros.svh"

module screenshot_transfer_session_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sts_in_if.sink    in_i,
  sts_cfg_if.sink   cfg_i,
  sts_out_if.source out_o
);

  sts_pkg::item_t   push_item;
  sts_pkg::item_t   head_item;
  sts_pkg::q_stat_t q_stat;
  logic             push;
  logic             pop;
  logic [31:0]      window;

  // Classifier: register file, length checks and packet sizing.
  sts_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_stat.full),
    .push_o   (push),
    .item_o   (push_item),
    .window_o (window)
  );

  // Queue that lets the classifier and the engine stall on their own.
  sts_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (q_stat)
  );

  // Session engine with the output register.
  sts_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (head_item),
    .stat_i   (q_stat),
    .window_i (window),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  // The queue can never be full and empty at once.
  `STS_NEVER(a_queue_status, q_stat.full && q_stat.empty, "queue full and empty")
  // The engine only takes a request when the queue holds one.
  `STS_ASSERT(a_pop_nonempty, pop |-> !q_stat.empty, "pop from empty queue")
  // A new result only shows up after the engine took a request.
  `STS_ASSERT(a_result_source, $rose(out_o.valid) |-> $past(pop), "result without request")

endmodule

`default_nettype wire

// File: dv/sts_tb_intf.sv
// ----------------------------------------------------------------------------
// Session unit testbench channel notes
// The channel interfaces themselves live with the RTL; this file only groups
// the request helpers that the stimulus and the checker share.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_tb_pkg;
  import sts_pkg::*;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  msg_opcode;
    logic [7:0]  msg_length;
    logic [15:0] msg_session;
    logic [15:0] msg_sequence;
    logic [15:0] requester_id;
    logic [63:0] now_ms;
    logic        frame_present;
    logic [19:0] frame_bytes;
    logic [15:0] capacity;
  } request_t;
endpackage

`default_nettype wire

// File: dv/sts_session_checker.sv
// ----------------------------------------------------------------------------
// Session unit checker
// Watches the request, result and register channels, predicts every result
// and compares it field by field with what the unit returns.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_session_checker
  import sts_pkg::*;
  import sts_tb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sts_in_if.sink    req_mon,
  sts_cfg_if.sink   cfg_mon,
  sts_out_if.sink   res_mon,
  output int        fail_count,
  output int        pending_count
);

  localparam logic [2:0] PH_IDLE = 3'd0, PH_CAPTURING = 3'd1, PH_BEGIN = 3'd2,
                         PH_DATA = 3'd3, PH_END = 3'd4, PH_COMPLETE = 3'd5,
                         PH_FAILED = 3'd6;

  logic [31:0] capture_timeout, ack_timeout, done_window;
  logic [2:0]  phase;
  logic [15:0] session_id, seq_no;
  logic [63:0] deadline, done_time;
  logic        ack_wait;
  logic [1:0]  retries;
  logic [10:0] pend_len;
  logic [1:0]  pend_kind;
  logic [17:0] frame_offset;
  logic [8:0]  pend_payload;
  logic [8:0]  data_count;

  res_t expected_results[$];

  function automatic void clear_session();
    phase = PH_IDLE; session_id = '0; seq_no = '0; deadline = '0;
    ack_wait = 1'b0; retries = '0; pend_len = '0; pend_kind = '0;
    frame_offset = '0; pend_payload = '0; data_count = '0; done_time = '0;
  endfunction

  function automatic void reply_with(inout res_t r, input status_e st, input logic rel);
    r.reply = 1'b1;
    r.status = st;
    r.release_res = rel;
  endfunction

  function automatic void host_message(input request_t q, inout res_t r);
    logic len_ok, active, recent;
    active = phase >= PH_CAPTURING && phase <= PH_END;
    case (q.msg_opcode)
      OP_START:  len_ok = q.msg_length == 8'd1;
      OP_ACK:    len_ok = q.msg_length == 8'd5;
      OP_FINISH, OP_CANCEL: len_ok = q.msg_length == 8'd3;
      default:   len_ok = 1'b0;
    endcase
    if (!len_ok) begin
      reply_with(r, ST_BAD_LEN, 1'b0);
    end else if (q.msg_opcode == OP_START) begin
      if (active) reply_with(r, ST_BUSY, 1'b0);
      else if (q.requester_id == 16'd0) reply_with(r, ST_BAD_ID, 1'b0);
      else begin
        clear_session();
        phase = PH_CAPTURING;
        session_id = q.requester_id;
        deadline = q.now_ms + 64'(capture_timeout);
        r.capture = 1'b1;
        r.release_res = 1'b1;
      end
    end else if (q.msg_session == 16'd0 || q.msg_session != session_id) begin
      reply_with(r, ST_BAD_STATE, 1'b0);
    end else if (q.msg_opcode == OP_ACK) begin
      if (!ack_wait || q.msg_sequence != seq_no) begin
        reply_with(r, ST_BAD_STATE, 1'b0);
      end else begin
        ack_wait = 1'b0; retries = '0; pend_len = '0;
        seq_no = seq_no + 16'd1;
        if (phase == PH_BEGIN) phase = PH_DATA;
        else if (phase == PH_DATA) begin
          frame_offset = frame_offset + 18'(pend_payload);
          data_count = data_count + 9'd1;
          if (frame_offset == 18'(FRAME_BYTES)) phase = PH_END;
        end else if (phase == PH_END) begin
          phase = PH_COMPLETE;
          done_time = q.now_ms;
          reply_with(r, ST_OK, 1'b1);
        end else begin
          reply_with(r, ST_BAD_STATE, 1'b0);
        end
      end
    end else begin
      recent = phase == PH_COMPLETE && (q.now_ms - done_time) < 64'(done_window);
      if (!recent && !(q.msg_opcode == OP_CANCEL && active)) begin
        reply_with(r, ST_BAD_STATE, 1'b0);
      end else begin
        clear_session();
        reply_with(r, ST_OK, 1'b1);
      end
    end
  endfunction

  function automatic void packet_request(input request_t q, inout res_t r);
    int room, cnt, remain;
    room = q.capacity < PACKET_BUFFER_BYTES ? int'(q.capacity) : PACKET_BUFFER_BYTES;
    if (phase < PH_BEGIN || phase > PH_END) return;
    if (ack_wait && q.now_ms < deadline) return;
    if (ack_wait && retries >= MAX_RETRIES) return;
    if (pend_len == 0) begin
      if (phase == PH_BEGIN) begin
        if (BEGIN_PACKET_BYTES > room) return;
        pend_len = 11'(BEGIN_PACKET_BYTES); pend_kind = PK_BEGIN;
      end else if (phase == PH_END) begin
        if (END_PACKET_BYTES > room) return;
        pend_len = 11'(END_PACKET_BYTES); pend_kind = PK_END;
      end else begin
        if (int'(q.capacity) <= DATA_HEADER) return;
        cnt = (int'(q.capacity) - DATA_HEADER) & ~1;
        if (cnt > MAX_CHUNK) cnt = MAX_CHUNK;
        remain = frame_offset < FRAME_BYTES ? FRAME_BYTES - int'(frame_offset) : 0;
        if (cnt > remain) cnt = remain;
        if (cnt == 0) return;
        pend_payload = 9'(cnt);
        if (DATA_HEADER + cnt > PACKET_BUFFER_BYTES) return;
        pend_len = 11'(DATA_HEADER + cnt); pend_kind = PK_DATA;
      end
    end else if (int'(pend_len) > int'(q.capacity)) begin
      return;
    end
    r.packet_kind = pend_kind;
    r.packet_sequence = seq_no;
    if (pend_kind == PK_DATA) begin
      r.packet_offset = frame_offset;
      r.packet_payload_bytes = pend_payload;
    end
    r.packet_len = pend_len;
    if (pend_kind == PK_END) r.packet_total = data_count;
  endfunction

  function automatic res_t session_step(request_t q);
    res_t r;
    r = '0;
    case (q.command)
      CMD_MSG: host_message(q, r);
      CMD_CAPTURED: begin
        if (phase == PH_CAPTURING && q.frame_present &&
            q.frame_bytes == 20'(FRAME_BYTES)) begin
          phase = PH_BEGIN;
          r.accepted = 1'b1;
        end
      end
      CMD_REQUEST: packet_request(q, r);
      CMD_SENT: begin
        if (pend_len != 0) begin
          if (ack_wait && retries < 2'd3) retries = retries + 2'd1;
          ack_wait = 1'b1;
          deadline = q.now_ms + 64'(ack_timeout);
        end
      end
      CMD_POLL: begin
        if ((ack_wait && q.now_ms >= deadline && retries >= MAX_RETRIES) ||
            (phase == PH_CAPTURING && q.now_ms >= deadline)) begin
          phase = PH_FAILED;
          ack_wait = 1'b0;
          reply_with(r, ST_TIMEOUT, 1'b1);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    request_t q;
    res_t e;
    if (!rst_ni) begin
      capture_timeout <= CAPTURE_TIMEOUT_RST;
      ack_timeout <= ACK_TIMEOUT_RST;
      done_window <= WINDOW_RST;
      clear_session();
      expected_results.delete();
      fail_count = 0;
      pending_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_CAPTURE: capture_timeout <= cfg_mon.data;
          CFG_ACK:     ack_timeout <= cfg_mon.data;
          CFG_WINDOW:  done_window <= cfg_mon.data;
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready) begin
        q = '{req_mon.command, req_mon.msg_opcode, req_mon.msg_length,
              req_mon.msg_session, req_mon.msg_sequence, req_mon.requester_id,
              req_mon.now_ms, req_mon.frame_present, req_mon.frame_bytes,
              req_mon.capacity};
        expected_results.push_back(session_step(q));
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          check_field("reply", e.reply, res_mon.reply);
          check_field("status", e.status, res_mon.status);
          check_field("capture", e.capture, res_mon.capture);
          check_field("release_res", e.release_res, res_mon.release_res);
          check_field("accepted", e.accepted, res_mon.accepted);
          check_field("packet_kind", e.packet_kind, res_mon.packet_kind);
          check_field("packet_sequence", e.packet_sequence, res_mon.packet_sequence);
          check_field("packet_offset", e.packet_offset, res_mon.packet_offset);
          check_field("packet_payload_bytes", e.packet_payload_bytes,
                      res_mon.packet_payload_bytes);
          check_field("packet_len", e.packet_len, res_mon.packet_len);
          check_field("packet_total", e.packet_total, res_mon.packet_total);
        end
      end
      pending_count = expected_results.size();
    end
  end

endmodule

`default_nettype wire

// File: dv/screenshot_transfer_session_unit_tb.sv
// ----------------------------------------------------------------------------
// Screenshot transfer session unit testbench
// Drives host messages, captures, packet requests, sent marks and polls in
// bursts, with a stalling consumer, and leaves checking to the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module screenshot_transfer_session_unit_tb;
  import sts_pkg::*;
  import sts_tb_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_count;
  int   cycle_count;
  bit   long_stall;
  bit   stall_done;

  sts_in_if  req_ch();
  sts_out_if res_ch();
  sts_cfg_if cfg_ch();

  screenshot_transfer_session_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch.sink),
    .cfg_i (cfg_ch.sink),
    .out_o (res_ch.source)
  );

  sts_session_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_ch.sink),
    .cfg_mon      (cfg_ch.sink),
    .res_mon      (res_ch.sink),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Time moves forward mostly in small steps so deadlines are crossed in both
  // directions; a wide random jump now and then exercises 64-bit wraparound.
  logic [63:0] clock_ms;
  logic [15:0] active_session;
  logic [15:0] guess_seq;

  // The consumer stalls on its own pattern. Once, a long hold-off lets the
  // queue fill up so that the unit has to drop input ready.
  initial begin
    res_ch.ready = 1'b0;
    stall_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_stall && !stall_done) begin
        res_ch.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
        stall_done = 1'b1;
      end
      case (cycle_count % 64 < 20)
        1'b1: res_ch.ready <= 1'b1;
        default: res_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Cycle counter and watchdog.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("screenshot_transfer_session_unit test failed");
        $finish;
      end
    end
  end

  // Offers one request and holds it until the unit accepts it. Between
  // bursts the sender idles for a random number of cycles.
  int burst_left;
  task automatic send_request(request_t q);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(10, 40);
    end
    burst_left--;
    req_ch.valid         <= 1'b1;
    req_ch.command       <= q.command;
    req_ch.msg_opcode    <= q.msg_opcode;
    req_ch.msg_length    <= q.msg_length;
    req_ch.msg_session   <= q.msg_session;
    req_ch.msg_sequence  <= q.msg_sequence;
    req_ch.requester_id  <= q.requester_id;
    req_ch.now_ms        <= q.now_ms;
    req_ch.frame_present <= q.frame_present;
    req_ch.frame_bytes   <= q.frame_bytes;
    req_ch.capacity      <= q.capacity;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // One register write, after which the channel is left idle.
  task automatic write_register(cfg_idx_e idx, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every outstanding result has come back, plus a short pause
  // for anything still inside the unit's pipeline.
  task automatic drain();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic request_t blank_request(cmd_e c);
    request_t q;
    q = '0;
    q.command = c;
    q.now_ms = clock_ms;
    return q;
  endfunction

  function automatic request_t host_msg(op_e op, logic [15:0] sess);
    request_t q;
    q = blank_request(CMD_MSG);
    q.msg_opcode = op;
    q.msg_length = (op == OP_START) ? 8'd1 : (op == OP_ACK) ? 8'd5 : 8'd3;
    q.msg_session = sess;
    q.requester_id = sess;
    q.msg_sequence = guess_seq;
    return q;
  endfunction

  // Mostly well-formed traffic for an open session, with noise mixed in.
  function automatic request_t random_request();
    request_t q;
    int pick;
    pick = $urandom_range(0, 99);
    clock_ms = clock_ms + 64'($urandom_range(0, 1500));
    if ($urandom_range(0, 199) == 0) clock_ms = {$urandom, $urandom};
    if (pick < 5) begin
      q.command = 3'($urandom_range(0, 7));
      q.msg_opcode = 8'($urandom);
      q.msg_length = 8'($urandom);
      q.msg_session = 16'($urandom);
      q.msg_sequence = 16'($urandom);
      q.requester_id = 16'($urandom);
      q.now_ms = {$urandom, $urandom};
      q.frame_present = 1'($urandom);
      q.frame_bytes = 20'($urandom);
      q.capacity = 16'($urandom);
    end else if (pick < 12) begin
      active_session = $urandom_range(0, 9) == 0 ? 16'd0 : 16'($urandom);
      q = host_msg(OP_START, active_session);
      guess_seq = '0;
    end else if (pick < 20) begin
      q = blank_request(CMD_CAPTURED);
      q.frame_present = $urandom_range(0, 7) != 0;
      q.frame_bytes = $urandom_range(0, 7) != 0 ? 20'(FRAME_BYTES) : 20'($urandom);
    end else if (pick < 50) begin
      q = blank_request(CMD_REQUEST);
      q.capacity = $urandom_range(0, 9) == 0 ? 16'($urandom) :
                   16'($urandom_range(0, 1100));
    end else if (pick < 65) begin
      q = blank_request(CMD_SENT);
    end else if (pick < 85) begin
      q = host_msg(OP_ACK, active_session);
      if ($urandom_range(0, 9) == 0) q.msg_sequence = 16'($urandom);
      else guess_seq = guess_seq + 16'd1;
    end else if (pick < 93) begin
      q = blank_request(CMD_POLL);
    end else begin
      q = host_msg($urandom_range(0, 1) ? OP_FINISH : OP_CANCEL, active_session);
    end
    return q;
  endfunction

  // One full upload with big chunks: start, capture, begin, data until the
  // frame is done, end, completion and finish.
  task automatic full_upload(logic [15:0] sess);
    request_t q;
    guess_seq = '0;
    send_request(host_msg(OP_START, sess));
    q = blank_request(CMD_CAPTURED);
    q.frame_present = 1'b1;
    q.frame_bytes = 20'(FRAME_BYTES);
    send_request(q);
    for (int k = 0; k < 312; k++) begin
      q = blank_request(CMD_REQUEST);
      q.capacity = 16'hFFFF;
      send_request(q);
      send_request(blank_request(CMD_SENT));
      send_request(host_msg(OP_ACK, sess));
      guess_seq = guess_seq + 16'd1;
    end
    send_request(host_msg(OP_FINISH, sess));
  endtask

  initial begin
    request_t q;
    rst_ni = 1'b0;
    long_stall = 1'b0;
    burst_left = 0;
    clock_ms = 64'd1000;
    active_session = 16'h1234;
    guess_seq = '0;
    req_ch.valid = 1'b0;
    req_ch.command = '0;
    req_ch.msg_opcode = '0;
    req_ch.msg_length = '0;
    req_ch.msg_session = '0;
    req_ch.msg_sequence = '0;
    req_ch.requester_id = '0;
    req_ch.now_ms = '0;
    req_ch.frame_present = 1'b0;
    req_ch.frame_bytes = '0;
    req_ch.capacity = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_CAPTURE;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: bad lengths and ids, busy start, unknown command and
    // opcode, a capture timeout, a stray sent mark and all-ones fields.
    q = host_msg(OP_START, 16'd0);
    send_request(q);
    q = host_msg(OP_ACK, 16'd5);
    q.msg_length = 8'd255;
    send_request(q);
    q = blank_request(CMD_MSG);
    q.msg_opcode = 8'hFF;
    q.msg_length = 8'd3;
    send_request(q);
    q = '1;
    send_request(q);
    send_request(blank_request(CMD_SENT));
    send_request(host_msg(OP_START, 16'hFFFF));
    send_request(host_msg(OP_START, 16'h0001));
    send_request(host_msg(OP_FINISH, 16'h0002));
    clock_ms = clock_ms + 64'd40000;
    send_request(blank_request(CMD_POLL));
    send_request(host_msg(OP_CANCEL, 16'hFFFF));
    drain();

    // Full run with the reset register values, then the registers are set to the extremes.
    full_upload(16'h00A5);
    drain();
    write_register(CFG_CAPTURE, 32'd0);
    write_register(CFG_ACK, 32'd0);
    write_register(CFG_WINDOW, 32'hFFFF_FFFF);

    // An ack timeout that runs out of retries, with the ack wait set to zero.
    send_request(host_msg(OP_START, 16'h0042));
    q = blank_request(CMD_CAPTURED);
    q.frame_present = 1'b1;
    q.frame_bytes = 20'(FRAME_BYTES);
    send_request(q);
    for (int k = 0; k < 5; k++) begin
      q = blank_request(CMD_REQUEST);
      q.capacity = 16'd17;
      send_request(q);
      send_request(blank_request(CMD_SENT));
    end
    send_request(blank_request(CMD_POLL));
    drain();

    // Random phases, each with its own register settings.
    for (int ph = 0; ph < 4; ph++) begin
      write_register(CFG_CAPTURE, ph == 3 ? 32'hFFFF_FFFF : $urandom_range(0, 20000));
      write_register(CFG_ACK, ph == 3 ? 32'hFFFF_FFFF : $urandom_range(0, 4000));
      write_register(CFG_WINDOW, ph == 2 ? 32'd0 : $urandom);
      for (int n = 0; n < 260; n++) begin
        if (ph == 1 && n == 100) long_stall = 1'b1;
        send_request(random_request());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("screenshot_transfer_session_unit test passed");
    end else begin
      $display("screenshot_transfer_session_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+src
src/sts_pkg.sv
src/sts_intf.sv
src/sts_front.sv
src/sts_queue.sv
src/sts_back.sv
src/screenshot_transfer_session_unit.sv
dv/sts_tb_intf.sv
dv/sts_session_checker.sv
dv/screenshot_transfer_session_unit_tb.sv
